[src/orf_pkg.sv]
// ----------------------------------------------------------------------------
// orf_pkg
// Shared types, codes and helpers for the overlay route and filter unit.
// ----------------------------------------------------------------------------
package orf_pkg;

  // Item action codes
  typedef enum logic [1:0] {
    ActOutbound = 2'd0,
    ActInbound  = 2'd1,
    ActAddRoute = 2'd2
  } orf_action_e;

  // Verdict codes
  typedef enum logic [3:0] {
    VerDrop       = 4'd0,
    VerLoop       = 4'd1,
    VerPeer       = 4'd2,
    VerPeerEncap  = 4'd3,
    VerTun        = 4'd4,
    VerTunStrip   = 4'd5,
    VerRtStored   = 4'd6,
    VerRtIgnored  = 4'd7,
    VerRtFull     = 4'd8
  } orf_verdict_e;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StScan,
    StFilter,
    StDone
  } orf_state_e;

  // One stored route
  typedef struct packed {
    logic [31:0] dst;
    logic [31:0] mask;
    logic [31:0] hop;
  } orf_route_t;

  localparam int unsigned RouteWidth = $bits(orf_route_t);

  localparam logic [15:0] MinHeaderLen  = 16'd20;
  localparam logic [3:0]  IpVersion4    = 4'd4;
  localparam logic [7:0]  ProtoIpIp     = 8'h04;
  localparam logic [31:0] AddrBroadcast = 32'hFFFF_FFFF;
  localparam logic [31:0] McastMask     = 32'hF000_0000;
  localparam logic [31:0] McastBase     = 32'hE000_0000;

  // Register byte addresses
  localparam logic [2:0] RegOwnAddress = 3'h0;
  localparam logic [2:0] RegOwnNetmask = 3'h4;

  // True when an address sits in the own subnet
  function automatic logic in_subnet(logic [31:0] addr, logic [31:0] own,
                                     logic [31:0] mask);
    return (addr & mask) == (own & mask);
  endfunction

endpackage

[src/orf_ram.sv]
// ----------------------------------------------------------------------------
// orf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module orf_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/overlay_route_and_filter_unit.sv]
// An accepted beat passes through StDecide to StDone; an outbound beat that scans the table
// also passes through StScan and StFilter, and one that meets an empty table through StFilter.
// One beat at a time: the next beat is taken once the result has moved to the output register,
// which waits in StDone while the output register holds a stalled beat.
// Reset clears both configuration registers and the route count; RAM contents stay
// as they were and are never read before they are written.
// ----------------------------------------------------------------------------
// overlay_route_and_filter_unit
// Routes and filters IPv4 headers for an overlay tunnel, with a first-match
// route table held in RAM and scanned by a small sequencer.
// ----------------------------------------------------------------------------
module overlay_route_and_filter_unit import orf_pkg::*; #(
  parameter int unsigned ROUTE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] packet_length_i,
  input  logic [3:0]  ip_version_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [31:0] route_mask_i,
  input  logic [31:0] route_next_hop_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  verdict_o,
  output logic [31:0] outer_src_o,
  output logic [31:0] outer_dst_o
);

  localparam int unsigned AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ROUTE_DEPTH + 1);

  // Configuration registers
  logic [31:0] own_addr_q, own_mask_q;
  logic        cfg_wr;

  // Sequencer and captured beat
  orf_state_e   state_q, state_d;
  orf_action_e  act_q, act_d;
  logic         len_ok_q, len_ok_d, ver_ok_q, ver_ok_d;
  logic [7:0]   proto_q, proto_d;
  logic [31:0]  src_q, src_d, dst_q, dst_d, rmask_q, rmask_d, nh_q, nh_d;
  logic [CW-1:0] ptr_q, ptr_d, cnt_q, cnt_d;

  // Result and output register
  orf_verdict_e res_verdict_q, res_verdict_d;
  logic [31:0]  res_src_q, res_src_d, res_dst_q, res_dst_d;
  logic         out_valid_q, out_valid_d, out_load;
  logic [3:0]   out_verdict_q;
  logic [31:0]  out_src_q, out_dst_q;

  // Route RAM
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [RouteWidth-1:0] ram_wdata, ram_rdata;

  // Configuration write and read back
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      own_mask_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegOwnNetmask[2]) begin
        own_mask_q <= pwdata;
      end else begin
        own_addr_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == RegOwnAddress[2]) ? own_addr_q : own_mask_q;

  // Route table storage
  orf_ram #(
    .WIDTH (RouteWidth),
    .DEPTH (ROUTE_DEPTH)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != StIdle);

  // Next state, scan control and result
  always_comb begin
    orf_route_t  entry;
    logic        encap;
    logic [31:0] fs, fd;
    logic        allowed;

    entry   = orf_route_t'(ram_rdata);
    encap   = 1'b0;
    fs      = '0;
    fd      = '0;
    allowed = 1'b0;

    state_d       = state_q;
    act_d         = act_q;
    len_ok_d      = len_ok_q;
    ver_ok_d      = ver_ok_q;
    proto_d       = proto_q;
    src_d         = src_q;
    dst_d         = dst_q;
    rmask_d       = rmask_q;
    nh_d          = nh_q;
    ptr_d         = ptr_q;
    cnt_d         = cnt_q;
    res_verdict_d = res_verdict_q;
    res_src_d     = res_src_q;
    res_dst_d     = res_dst_q;
    out_load      = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;

    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = {dst_q, rmask_q, nh_q};
    ram_re    = 1'b0;
    ram_raddr = ptr_q[AW-1:0];

    unique case (state_q)
      StIdle: begin
        // Capture the beat
        if (in_valid_i) begin
          act_d    = orf_action_e'(action_i);
          len_ok_d = (packet_length_i >= MinHeaderLen);
          ver_ok_d = (ip_version_i == IpVersion4);
          proto_d  = ip_protocol_i;
          src_d    = src_addr_i;
          dst_d    = dst_addr_i;
          rmask_d  = route_mask_i;
          nh_d     = route_next_hop_i;
          state_d  = StDecide;
        end
      end

      StDecide: begin
        res_verdict_d = VerDrop;
        res_src_d     = '0;
        res_dst_d     = '0;
        state_d       = StDone;
        unique case (act_q)
          ActOutbound: begin
            if (len_ok_q && ver_ok_q) begin
              if (dst_q == own_addr_q) begin
                res_verdict_d = VerLoop;
                res_src_d     = src_q;
                res_dst_d     = dst_q;
              end else if (cnt_q == '0) begin
                nh_d    = '0;
                state_d = StFilter;
              end else begin
                // Start the scan at the oldest entry
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = CW'(1);
                state_d   = StScan;
              end
            end
          end
          ActInbound: begin
            if (len_ok_q) begin
              res_verdict_d = (proto_q == ProtoIpIp) ? VerTunStrip : VerTun;
              res_src_d     = src_q;
              res_dst_d     = dst_q;
            end
          end
          ActAddRoute: begin
            if (nh_q == own_addr_q) begin
              res_verdict_d = VerRtIgnored;
            end else if (cnt_q == CW'(ROUTE_DEPTH)) begin
              res_verdict_d = VerRtFull;
            end else begin
              ram_we        = 1'b1;
              cnt_d         = cnt_q + CW'(1);
              res_verdict_d = VerRtStored;
            end
          end
          default: begin
            res_verdict_d = VerDrop;
          end
        endcase
      end

      StScan: begin
        // Compare the entry read last cycle; stop at first match or table end
        if ((dst_q & entry.mask) == entry.dst) begin
          nh_d    = entry.hop;
          state_d = StFilter;
        end else if (ptr_q == cnt_q) begin
          nh_d    = '0;
          state_d = StFilter;
        end else begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CW'(1);
        end
      end

      StFilter: begin
        // Check the pair as sent against subnet, broadcast and multicast
        encap   = (nh_q != '0);
        fs      = encap ? own_addr_q : src_q;
        fd      = encap ? nh_q : dst_q;
        allowed = (in_subnet(fs, own_addr_q, own_mask_q) &&
                   in_subnet(fd, own_addr_q, own_mask_q)) ||
                  (fd == AddrBroadcast) ||
                  ((fd & McastMask) == McastBase);
        if (allowed) begin
          res_verdict_d = encap ? VerPeerEncap : VerPeer;
          res_src_d     = fs;
          res_dst_d     = fd;
        end else begin
          res_verdict_d = VerDrop;
          res_src_d     = '0;
          res_dst_d     = '0;
        end
        state_d = StDone;
      end

      StDone: begin
        // Hand over to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    len_ok_q      <= len_ok_d;
    ver_ok_q      <= ver_ok_d;
    proto_q       <= proto_d;
    src_q         <= src_d;
    dst_q         <= dst_d;
    rmask_q       <= rmask_d;
    nh_q          <= nh_d;
    res_verdict_q <= res_verdict_d;
    res_src_q     <= res_src_d;
    res_dst_q     <= res_dst_d;
    if (out_load) begin
      out_verdict_q <= res_verdict_q;
      out_src_q     <= res_src_q;
      out_dst_q     <= res_dst_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;
  assign outer_src_o = out_src_q;
  assign outer_dst_o = out_dst_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ROUTE_DEPTH))
    else $error("route count beyond table depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cnt_q < CW'(ROUTE_DEPTH)) && (state_q == StDecide))
    else $error("route write with no room");

  a_scan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (ptr_q != '0) && (ptr_q <= cnt_q))
    else $error("scan pointer outside stored entries");

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == StDecide))
    else $error("accepted beat not decoded");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a held beat");
`endif

endmodule
